// ===== rtl/icvas_pkg.sv =====
package icvas_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 3;
    localparam int RETRY_W  = 4;
    localparam int CFG_W    = 4;

    // Configuration register indexes
    localparam logic CFG_SECOND_INDEX_USED = 1'b0;
    localparam logic CFG_RETRY_LIMIT       = 1'b1;

    // Configuration reset values
    localparam logic               SECOND_INDEX_USED_RST = 1'b1;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST       = 4'd2;

    // Request codes
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONFIRM = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_EVENT   = 2'd3;

    // Completion status codes
    localparam logic [STATUS_W-1:0] ST_FAILED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_READ   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SAME   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DIFF   = 3'd4;

    // Issued commands
    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PI      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SI      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONFIRM = 3'd4;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_PI_R = 4'd1,
        PH_PI_C = 4'd2,
        PH_PI_W = 4'd3,
        PH_SI_R = 4'd4,
        PH_SI_C = 4'd5,
        PH_SI_W = 4'd6,
        PH_RD   = 4'd7,
        PH_CMP  = 4'd8,
        PH_WR   = 4'd9
    } icvas_phase_t;

    typedef struct packed {
        icvas_phase_t       phase;
        logic [RETRY_W-1:0] retry_count;
        logic               busy;
    } icvas_state_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             busy_res;
        logic             finished;
        logic             marked_stored;
    } icvas_result_t;

    // Status that the given step counts as success
    function automatic logic status_ok(icvas_phase_t ph, logic [STATUS_W-1:0] st);
        logic ok;
        case (ph)
            PH_RD:   ok = (st == ST_READ);
            PH_CMP:  ok = (st == ST_SAME) || (st == ST_DIFF);
            default: ok = (st == ST_STORED);
        endcase
        return ok;
    endfunction

    // Command that a step issues again on retry
    function automatic logic [CMD_W-1:0] phase_command(icvas_phase_t ph);
        logic [CMD_W-1:0] cmd;
        case (ph)
            PH_PI_R, PH_PI_C, PH_PI_W: cmd = CMD_PI;
            PH_SI_R, PH_SI_C, PH_SI_W: cmd = CMD_SI;
            PH_RD:                     cmd = CMD_READ;
            PH_CMP:                    cmd = CMD_CONFIRM;
            PH_WR:                     cmd = CMD_WRITE;
            default:                   cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

endpackage

// ===== rtl/icvas_step.sv =====
module icvas_step
    import icvas_pkg::*;
(
    input  icvas_state_t          cur,
    input  logic [FUNC_W-1:0]     func,
    input  logic [STATUS_W-1:0]   access_status,
    input  logic                  second_index_used,
    input  logic [RETRY_W-1:0]    retry_limit,
    output icvas_state_t          nxt,
    output icvas_result_t         res
);

    logic [CMD_W-1:0] cmd;
    logic             fin;
    logic             stored;
    logic             retry;

    // Retry while the status is wrong and the limit is not reached
    assign retry = (cur.retry_count < retry_limit) && !status_ok(cur.phase, access_status);

    // Work out the next state and the command for one word
    always_comb
    begin
        nxt    = cur;
        cmd    = CMD_NONE;
        fin    = 1'b0;
        stored = 1'b0;
        if (func != FUNC_EVENT)
        begin
            // Start request: drop any running sequence and restart
            nxt.busy        = 1'b1;
            nxt.retry_count = '0;
            cmd             = CMD_PI;
            case (func)
                FUNC_READ:    nxt.phase = second_index_used ? PH_PI_R : PH_SI_R;
                FUNC_WRITE:   nxt.phase = second_index_used ? PH_PI_W : PH_SI_W;
                default:      nxt.phase = second_index_used ? PH_PI_C : PH_SI_C;
            endcase
        end
        else if (cur.phase != PH_IDLE)
        begin
            if (cur.phase > PH_WR)
            begin
                // Undefined phase code: fall back to idle, busy unchanged
                nxt.phase = PH_IDLE;
            end
            else if (retry)
            begin
                nxt.retry_count = cur.retry_count + 1'b1;
                cmd             = phase_command(cur.phase);
            end
            else
            begin
                // Advance on success or once retries run out
                nxt.retry_count = '0;
                case (cur.phase)
                    PH_PI_R:
                    begin
                        nxt.phase = PH_SI_R;
                        cmd       = CMD_SI;
                    end
                    PH_PI_C:
                    begin
                        nxt.phase = PH_SI_C;
                        cmd       = CMD_SI;
                    end
                    PH_PI_W:
                    begin
                        nxt.phase = PH_SI_W;
                        cmd       = CMD_SI;
                    end
                    PH_SI_R:
                    begin
                        nxt.phase = PH_RD;
                        cmd       = CMD_READ;
                    end
                    PH_SI_C:
                    begin
                        nxt.phase = PH_CMP;
                        cmd       = CMD_CONFIRM;
                    end
                    PH_SI_W:
                    begin
                        nxt.phase = PH_WR;
                        cmd       = CMD_WRITE;
                    end
                    PH_WR:
                    begin
                        nxt.phase = PH_IDLE;
                        nxt.busy  = 1'b0;
                        fin       = 1'b1;
                        stored    = 1'b1;
                    end
                    default:
                    begin
                        // Read or confirm done
                        nxt.phase = PH_IDLE;
                        nxt.busy  = 1'b0;
                        fin       = 1'b1;
                    end
                endcase
            end
        end
    end

    assign res.command       = cmd;
    assign res.busy_res      = nxt.busy;
    assign res.finished      = fin;
    assign res.marked_stored = stored;

endmodule

// ===== rtl/indexed_cv_access_sequencer_core.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    func, access_status
// out       output     out_valid / out_ready  command, busy_res, finished, marked_stored
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// Each input word yields one output word, visible in the cycle after it is accepted.
// The sequencer state and result register update in the same cycle, so one
// word per cycle is sustained while the output side keeps up.
// in_ready is high while the result register is empty or being drained.
// A stalled output holds the result register and blocks new input words.
// Reset (rst_n low) returns to idle, clears retries and busy, and loads the
// default configuration: secondary index used, retry limit of two.
module indexed_cv_access_sequencer_core
    import icvas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [STATUS_W-1:0] access_status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CMD_W-1:0]    command,
    output logic                busy_res,
    output logic                finished,
    output logic                marked_stored,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    icvas_state_t       state_reg;
    icvas_state_t       state_next;
    icvas_result_t      res_next;
    icvas_result_t      res_reg;
    logic               out_valid_reg;
    logic               second_index_used_reg;
    logic [RETRY_W-1:0] retry_limit_reg;
    logic               in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    icvas_step u_step (
        .cur               (state_reg),
        .func              (func),
        .access_status     (access_status),
        .second_index_used (second_index_used_reg),
        .retry_limit       (retry_limit_reg),
        .nxt               (state_next),
        .res               (res_next)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_index_used_reg <= SECOND_INDEX_USED_RST;
            retry_limit_reg       <= RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SECOND_INDEX_USED: second_index_used_reg <= cfg_data[0];
                CFG_RETRY_LIMIT:       retry_limit_reg       <= cfg_data[RETRY_W-1:0];
                default:               ;
            endcase
        end
    end

    // Advance sequencer state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.retry_count <= '0;
            state_reg.busy        <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = res_reg.command;
    assign busy_res      = res_reg.busy_res;
    assign finished      = res_reg.finished;
    assign marked_stored = res_reg.marked_stored;

    // Idle and busy agree
    a_idle_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) == !state_reg.busy)
        else $error("phase and busy flag disagree");

    // No retries are pending while idle
    a_idle_retry: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.busy |-> (state_reg.retry_count == '0))
        else $error("retry count left over while idle");

    // An accepted word always produces a result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

    // A finished sequence leaves the sequencer not busy
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.finished) |-> !res_reg.busy_res)
        else $error("finished result still busy");

    // A stored mark only comes with a finished sequence
    a_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.marked_stored) |-> res_reg.finished)
        else $error("stored mark without finish");

endmodule

// ===== tb/tb_indexed_cv_access_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_indexed_cv_access_sequencer_core
    import icvas_pkg::*;
();

    // Status codes with no meaning, all treated as failures
    localparam logic [STATUS_W-1:0] ST_RSVD5 = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RSVD6 = 3'd6;
    localparam logic [STATUS_W-1:0] ST_RSVD7 = 3'd7;

    localparam int LONG_HOLD = 300;

    // Track the sequencer state and hold the words it should produce
    class cv_access_scoreboard;
        logic               sec_used;
        logic [RETRY_W-1:0] limit_cap;
        icvas_phase_t       phase;
        logic [RETRY_W-1:0] retries;
        logic               busy;
        icvas_result_t      pending_words[$];
        int                 mismatches;

        function new();
            sec_used   = SECOND_INDEX_USED_RST;
            limit_cap  = RETRY_LIMIT_RST;
            phase      = PH_IDLE;
            retries    = '0;
            busy       = 1'b0;
            mismatches = 0;
        endfunction

        // Command a step sends out when it is entered or retried
        function logic [CMD_W-1:0] issued_by(icvas_phase_t ph);
            case (ph)
                PH_PI_R, PH_PI_C, PH_PI_W: return CMD_PI;
                PH_SI_R, PH_SI_C, PH_SI_W: return CMD_SI;
                PH_RD:                     return CMD_READ;
                PH_CMP:                    return CMD_CONFIRM;
                PH_WR:                     return CMD_WRITE;
                default:                   return CMD_NONE;
            endcase
        endfunction

        // Advance the tracked state by one accepted request and queue its word
        function void note_request(logic [FUNC_W-1:0] fn, logic [STATUS_W-1:0] st);
            icvas_result_t word;
            logic          good;
            word = '0;
            if (fn != FUNC_EVENT)
            begin
                // any start drops whatever was running
                busy         = 1'b1;
                retries      = '0;
                word.command = CMD_PI;
                case (fn)
                    FUNC_READ:  if (sec_used) phase = PH_PI_R; else phase = PH_SI_R;
                    FUNC_WRITE: if (sec_used) phase = PH_PI_W; else phase = PH_SI_W;
                    default:    if (sec_used) phase = PH_PI_C; else phase = PH_SI_C;
                endcase
            end
            else if (phase != PH_IDLE)
            begin
                if (phase == PH_RD)
                    good = (st == ST_READ);
                else if (phase == PH_CMP)
                    good = (st == ST_SAME) || (st == ST_DIFF);
                else
                    good = (st == ST_STORED);

                if (phase > PH_WR)
                    phase = PH_IDLE;
                else if (retries < limit_cap && !good)
                begin
                    retries      = retries + 1'b1;
                    word.command = issued_by(phase);
                end
                else
                begin
                    // success or out of retries: move to the next step
                    retries = '0;
                    case (phase)
                        PH_PI_R: phase = PH_SI_R;
                        PH_PI_C: phase = PH_SI_C;
                        PH_PI_W: phase = PH_SI_W;
                        PH_SI_R: phase = PH_RD;
                        PH_SI_C: phase = PH_CMP;
                        PH_SI_W: phase = PH_WR;
                        default:
                        begin
                            word.marked_stored = (phase == PH_WR);
                            word.finished      = 1'b1;
                            busy               = 1'b0;
                            phase              = PH_IDLE;
                        end
                    endcase
                    word.command = issued_by(phase);
                end
            end
            word.busy_res = busy;
            pending_words.push_back(word);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // Compare one output word against the oldest prediction
        function void check_word(logic [CMD_W-1:0] cmd, logic bsy, logic fin, logic sto);
            icvas_result_t want;
            if (pending_words.size() == 0)
            begin
                flag($sformatf("unexpected word command=%0d busy=%b finished=%b stored=%b",
                               cmd, bsy, fin, sto));
                return;
            end
            want = pending_words.pop_front();
            if (cmd !== want.command || bsy !== want.busy_res ||
                fin !== want.finished || sto !== want.marked_stored)
                flag($sformatf({"command %0d/%0d busy %b/%b finished %b/%b stored %b/%b",
                                " (expected/actual)"},
                               want.command, cmd, want.busy_res, bsy,
                               want.finished, fin, want.marked_stored, sto));
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [FUNC_W-1:0]   func          = FUNC_EVENT;
    logic [STATUS_W-1:0] access_status = ST_FAILED;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [CMD_W-1:0]    command;
    logic                busy_res;
    logic                finished;
    logic                marked_stored;
    logic                cfg_we        = 1'b0;
    logic                cfg_index     = CFG_SECOND_INDEX_USED;
    logic [CFG_W-1:0]    cfg_data      = '0;

    cv_access_scoreboard board = new();

    // Stimulus-side copy of the settings, used to shape well-formed sequences
    logic               sec_on    = SECOND_INDEX_USED_RST;
    logic [RETRY_W-1:0] limit_now = RETRY_LIMIT_RST;
    bit                 steady    = 1'b0;
    bit                 stall_req = 1'b0;
    int                 sent      = 0;

    indexed_cv_access_sequencer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .access_status (access_status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command       (command),
        .busy_res      (busy_res),
        .finished      (finished),
        .marked_stored (marked_stored),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Check results first, then record the word accepted at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_word(command, busy_res, finished, marked_stored);
            if (in_valid && in_ready)
                board.note_request(func, access_status);
        end
    end

    // Drive out_ready: random gaps, quiet stretches, and a long hold on request
    initial
    begin
        int gap_left;
        gap_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                gap_left  = LONG_HOLD;
            end
            else if (gap_left == 0 && !steady && $urandom_range(0, 2) == 0)
                gap_left = pick_gap();
            if (gap_left > 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one word, after an optional gap, and hold it until accepted
    task automatic send_word(logic [FUNC_W-1:0] fn, logic [STATUS_W-1:0] st);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid      <= 1'b0;
            func          <= FUNC_W'($urandom);
            access_status <= STATUS_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= fn;
        access_status <= st;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        // let the last accepted word be recorded before looking at the queue
        @(posedge clk);
        while (board.pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on back-to-back cycles; spare data bits are random
    task automatic set_config(logic sec, logic [RETRY_W-1:0] limit);
        logic [CFG_W-1:0] word;
        word    = CFG_W'($urandom);
        word[0] = sec;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SECOND_INDEX_USED;
        cfg_data  <= word;
        @(posedge clk);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we          <= 1'b0;
        board.sec_used  = sec;
        board.limit_cap = limit;
        sec_on          = sec;
        limit_now       = limit;
    endtask

    // Pick a status that the current step rejects
    function automatic logic [STATUS_W-1:0] wrong_status(logic [STATUS_W-1:0] a,
                                                         logic [STATUS_W-1:0] b);
        logic [STATUS_W-1:0] st;
        do
            st = STATUS_W'($urandom);
        while (st == a || st == b);
        return st;
    endfunction

    // One start followed by a proper completion run, with failures mixed in
    task automatic run_access();
        logic [FUNC_W-1:0]   fn;
        logic [STATUS_W-1:0] good_a;
        logic [STATUS_W-1:0] good_b;
        int                  steps;
        int                  fails;
        int                  r;
        fn = FUNC_W'($urandom_range(0, 2));
        send_word(fn, STATUS_W'($urandom));
        steps = sec_on ? 3 : 2;
        for (int s = 0; s < steps; s++)
        begin
            // abandon now and then so the next start lands while busy
            if ($urandom_range(0, 19) == 0)
                return;
            good_a = ST_STORED;
            good_b = ST_STORED;
            if (s == steps - 1 && fn == FUNC_READ)
            begin
                good_a = ST_READ;
                good_b = ST_READ;
            end
            else if (s == steps - 1 && fn == FUNC_CONFIRM)
            begin
                good_a = ST_SAME;
                good_b = ST_DIFF;
            end
            r = $urandom_range(0, 9);
            if (r < 5)
                fails = 0;
            else if (r < 8)
                fails = $urandom_range(1, 2);
            else
                fails = $urandom_range(0, limit_now + 1);
            if (fails > limit_now + 1)
                fails = limit_now + 1;
            repeat (fails) send_word(FUNC_EVENT, wrong_status(good_a, good_b));
            // once retries run out the step has already moved on
            if (fails <= limit_now)
                send_word(FUNC_EVENT, $urandom_range(0, 1) ? good_a : good_b);
        end
    endtask

    // Random traffic under one setting: long receiver hold, quiet stretch, pause
    task automatic run_phase(int words);
        int stop;
        stall_req = 1'b1;
        for (int part = 0; part < 4; part++)
        begin
            steady = (part == 1);
            if (part == 2)
                wait_drained();
            stop = sent + words / 4;
            while (sent < stop)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_word(FUNC_W'($urandom), STATUS_W'($urandom));
                else
                    run_access();
            end
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // completions with nothing running are dropped
        send_word(FUNC_EVENT, ST_FAILED);
        send_word(FUNC_EVENT, ST_RSVD7);
        // clean read through both index steps
        send_word(FUNC_READ, ST_RSVD7);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_READ);
        // write that runs out of retries on the primary index and write steps
        send_word(FUNC_WRITE, ST_FAILED);
        send_word(FUNC_EVENT, ST_FAILED);
        send_word(FUNC_EVENT, ST_RSVD5);
        send_word(FUNC_EVENT, ST_READ);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_RSVD6);
        send_word(FUNC_EVENT, ST_SAME);
        send_word(FUNC_EVENT, ST_DIFF);
        // confirm with one wrong status on the secondary index, ends on differs
        send_word(FUNC_CONFIRM, ST_SAME);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_SAME);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_DIFF);
        // restart while busy, then a clean write
        send_word(FUNC_CONFIRM, ST_FAILED);
        send_word(FUNC_WRITE, ST_STORED);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_STORED);
        send_word(FUNC_EVENT, ST_STORED);
        wait_drained();

        set_config(1'b0, 4'd0);
        run_phase(100);
        set_config(1'b1, 4'd15);
        run_phase(100);
        set_config(1'b0, 4'd15);
        run_phase(100);
        set_config(1'b1, 4'd0);
        run_phase(100);
        set_config(1'($urandom), RETRY_W'($urandom));
        run_phase(100);
        set_config(1'($urandom), RETRY_W'($urandom));
        run_phase(100);

        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Give up if the block hangs
    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
